// ===== design/pscr_pkg.sv =====
package pscr_pkg;

    localparam int unsigned NUM_CRIT = 3;
    localparam int unsigned ADDR_W   = 5;

    localparam logic [2:0] REG_TIME_STEP   = 3'd0;
    localparam logic [2:0] REG_VISCOSITY   = 3'd1;
    localparam logic [2:0] REG_ENABLE_MASK = 3'd2;
    localparam logic [2:0] REG_THREE_D     = 3'd3;
    localparam logic [2:0] REG_VORTEX_MODE = 3'd4;
    localparam logic [2:0] REG_START_MODE  = 3'd5;
    localparam logic [2:0] REG_RESUME_STEP = 3'd6;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    typedef logic [31:0] t_q16;

    function automatic logic [31:0] magnitude32(input logic [31:0] raw);
        magnitude32 = raw[31] ? (32'd0 - raw) : raw;
    endfunction

    function automatic logic [31:0] sat32(input logic [127:0] x);
        sat32 = (x[127:32] != '0) ? SAT32 : x[31:0];
    endfunction

endpackage

// ===== design/particle_stability_criteria_reducer.sv =====
// Stability-criteria reducer: takes one particle word and computes the Courant,
// diffusion and vortex numbers for the enabled criteria, folding them into
// per-step sums, per-step maxima and lifetime maxima. On the word marked last it
// emits the averages, the step maxima and the lifetime maxima, all unsigned
// Q16.16 with saturation. Every division and the speed square root run on one
// shared shift-subtract unit with a 32x32 multiplier ahead of it. The input stays
// stalled while a particle is worked through: the square root, each division, the
// multiplies and the sequencer steps. A last word also runs the three average
// divisions and waits while an earlier result is still held at the output.
// Configuration is through the APB port.
module particle_stability_criteria_reducer #(
    parameter int unsigned MAX_PARTICLES = 1048576
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_vel_x,
    input  logic [31:0] i_vel_y,
    input  logic [31:0] i_vel_z,
    input  logic [31:0] i_core_size,
    input  logic [31:0] i_vorticity,
    input  logic [31:0] i_strength_z,
    input  logic [23:0] i_step_number,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_courant_avg,
    output logic [31:0] o_courant_max,
    output logic [31:0] o_diffusion_avg,
    output logic [31:0] o_diffusion_max,
    output logic [31:0] o_vortex_avg,
    output logic [31:0] o_vortex_max,
    output logic [31:0] o_courant_life_max,
    output logic [31:0] o_diffusion_life_max,
    output logic [31:0] o_vortex_life_max
);
    import pscr_pkg::*;

    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_SQRT  = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_NEXT  = 4'd4;
    localparam logic [3:0] S_FOLD  = 4'd5;
    localparam logic [3:0] S_AVG   = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    // operation sequence slots
    localparam logic [4:0] OP_SQX   = 5'd0;
    localparam logic [4:0] OP_SQY   = 5'd1;
    localparam logic [4:0] OP_SQZ   = 5'd2;
    localparam logic [4:0] OP_SQRT  = 5'd3;
    localparam logic [4:0] OP_CNUM  = 5'd4;
    localparam logic [4:0] OP_CDIV  = 5'd5;
    localparam logic [4:0] OP_DS2   = 5'd6;
    localparam logic [4:0] OP_DNUM  = 5'd7;
    localparam logic [4:0] OP_DDIV  = 5'd8;
    localparam logic [4:0] OP_V0    = 5'd9;
    localparam logic [4:0] OP_V2D   = 5'd10;
    localparam logic [4:0] OP_VAL   = 5'd11;
    localparam logic [4:0] OP_VAH   = 5'd12;
    localparam logic [4:0] OP_VBL   = 5'd13;
    localparam logic [4:0] OP_VBH   = 5'd14;
    localparam logic [4:0] OP_V3D   = 5'd15;
    localparam logic [4:0] OP_DONE  = 5'd16;

    logic [31:0] r_time_step, r_viscosity;
    logic [2:0]  r_enable_mask;
    logic        r_three_d, r_vortex_mode, r_start_mode;
    logic [23:0] r_resume_step;

    logic [3:0]  r_state;
    logic [4:0]  r_op;
    logic [31:0] r_vx, r_vy, r_vz, r_size, r_vort, r_str;
    logic [23:0] r_step;
    logic        r_last;

    logic [31:0]  r_ma, r_mb;
    logic [63:0]  r_acc;     // sum of squares, then general product
    logic [127:0] r_num;     // dividend / radicand
    logic [63:0]  r_den;
    logic [63:0]  r_rem;
    logic [31:0]  r_q;
    logic         r_qsat;
    logic [6:0]   r_cnt;
    logic [63:0]  r_t1;      // temporaries
    logic [31:0]  r_v [NUM_CRIT];
    logic [1:0]   r_ci;

    logic [63:0]  r_sum [NUM_CRIT];
    logic [31:0]  r_smax [NUM_CRIT];
    logic [31:0]  r_lmax [NUM_CRIT];
    logic [31:0]  r_avg [NUM_CRIT];  // averages held until the output word is free
    logic [CNT_W-1:0] r_count;
    logic [31:0]  r_out [9];
    logic         r_ovalid;

    wire apb_wr = psel & penable & pwrite;
    wire in_acc = i_valid & ~o_stall;
    assign pready = 1'b1;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;

    always_comb begin
        unique case (paddr[4:2])
            REG_TIME_STEP:   prdata = r_time_step;
            REG_VISCOSITY:   prdata = r_viscosity;
            REG_ENABLE_MASK: prdata = {29'd0, r_enable_mask};
            REG_THREE_D:     prdata = {31'd0, r_three_d};
            REG_VORTEX_MODE: prdata = {31'd0, r_vortex_mode};
            REG_START_MODE:  prdata = {31'd0, r_start_mode};
            REG_RESUME_STEP: prdata = {8'd0, r_resume_step};
            default:         prdata = 32'd0;
        endcase
    end

    // shared multiplier
    logic [63:0] mprod;
    assign mprod = {32'd0, r_ma} * {32'd0, r_mb};

    // shift-subtract step (division)
    logic [64:0] div_rem_sh;
    logic        div_ge;
    assign div_rem_sh = {r_rem, r_num[127]};
    assign div_ge = div_rem_sh >= {1'b0, r_den};

    // square root step (two radicand bits per cycle)
    logic [65:0] sq_rem_sh;
    logic [65:0] sq_trial;
    logic        sq_ge;
    assign sq_rem_sh = {r_rem, r_num[63:62]};
    assign sq_trial  = {32'd0, r_q, 2'b01};
    assign sq_ge     = sq_rem_sh >= sq_trial;

    // next operation after op
    function automatic logic [4:0] next_op(input logic [4:0] op, input logic [2:0] en,
                                           input logic td, input logic vm);
        logic [4:0] n;
        n = OP_DONE;
        case (op)
            OP_SQX:  n = OP_SQY;
            OP_SQY:  n = td ? OP_SQZ : OP_SQRT;
            OP_SQZ:  n = OP_SQRT;
            OP_SQRT: n = OP_CNUM;
            OP_CNUM: n = OP_CDIV;
            OP_CDIV: n = en[1] ? OP_DS2 : (en[2] ? OP_V0 : OP_DONE);
            OP_DS2:  n = OP_DNUM;
            OP_DNUM: n = OP_DDIV;
            OP_DDIV: n = en[2] ? OP_V0 : OP_DONE;
            OP_V0:   n = !vm ? OP_DONE : (td ? OP_VAL : OP_V2D);
            OP_V2D:  n = OP_DONE;
            OP_VAL:  n = OP_VAH;
            OP_VAH:  n = OP_VBL;
            OP_VBL:  n = OP_VBH;
            OP_VBH:  n = OP_V3D;
            default: n = OP_DONE;
        endcase
        return n;
    endfunction

    logic [4:0] first_op;
    always_comb begin
        if (r_enable_mask[0])      first_op = OP_SQX;
        else if (r_enable_mask[1]) first_op = OP_DS2;
        else if (r_enable_mask[2]) first_op = OP_V0;
        else                       first_op = OP_DONE;
    end

    logic [31:0] mag_vort;
    assign mag_vort = magnitude32(r_vort);
    logic [CNT_W-1:0] max_cnt;
    assign max_cnt = CNT_W'(MAX_PARTICLES);
    logic [24:0] init_step;
    assign init_step = {1'b0, r_resume_step} + 25'd1;
    logic is_init;
    assign is_init = r_start_mode ? ({1'b0, r_step} == init_step) : (r_step == 24'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= '0; r_viscosity <= 32'd1; r_enable_mask <= 3'd7;
            r_three_d <= 1'b0; r_vortex_mode <= 1'b0; r_start_mode <= 1'b0;
            r_resume_step <= '0;
            r_state <= S_IDLE; r_ovalid <= 1'b0; r_count <= '0;
            r_op <= OP_DONE; r_ci <= '0; r_cnt <= '0;
            for (int i = 0; i < NUM_CRIT; i++) begin
                r_sum[i] <= '0; r_smax[i] <= '0; r_lmax[i] <= '0; r_v[i] <= '0;
            end
        end else begin
            if (apb_wr) begin
                unique case (paddr[4:2])
                    REG_TIME_STEP:   r_time_step   <= pwdata;
                    REG_VISCOSITY:   r_viscosity   <= pwdata;
                    REG_ENABLE_MASK: r_enable_mask <= pwdata[2:0];
                    REG_THREE_D:     r_three_d     <= pwdata[0];
                    REG_VORTEX_MODE: r_vortex_mode <= pwdata[0];
                    REG_START_MODE:  r_start_mode  <= pwdata[0];
                    REG_RESUME_STEP: r_resume_step <= pwdata[23:0];
                    default: ;
                endcase
            end
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;

            unique case (r_state)
                S_IDLE: if (in_acc) begin
                    r_vx <= i_vel_x; r_vy <= i_vel_y; r_vz <= i_vel_z;
                    r_size <= i_core_size; r_vort <= i_vorticity; r_str <= i_strength_z;
                    r_step <= i_step_number; r_last <= i_last;
                    for (int i = 0; i < NUM_CRIT; i++) r_v[i] <= '0;
                    r_acc <= '0;
                    if (r_count < max_cnt) begin
                        r_op <= first_op;
                        r_state <= S_NEXT;
                    end else begin
                        r_state <= i_last ? S_AVG : S_IDLE;
                        r_ci <= '0; r_cnt <= '0;
                        r_num <= '0; r_rem <= '0; r_q <= '0; r_qsat <= 1'b0;
                    end
                end
                // set up operands of r_op
                S_NEXT: begin
                    r_rem <= '0; r_q <= '0; r_qsat <= 1'b0; r_cnt <= '0;
                    case (r_op)
                        OP_SQX: begin
                            r_ma <= magnitude32(r_vx); r_mb <= magnitude32(r_vx);
                            r_state <= S_MUL;
                        end
                        OP_SQY: begin
                            r_ma <= magnitude32(r_vy); r_mb <= magnitude32(r_vy);
                            r_state <= S_MUL;
                        end
                        OP_SQZ: begin
                            r_ma <= magnitude32(r_vz); r_mb <= magnitude32(r_vz);
                            r_state <= S_MUL;
                        end
                        OP_SQRT: begin
                            r_num <= {64'd0, r_acc};
                            r_state <= S_SQRT;
                        end
                        OP_CNUM: begin
                            r_ma <= r_t1[31:0]; r_mb <= r_time_step;
                            r_state <= S_MUL;
                        end
                        OP_CDIV: begin
                            if (r_size == '0) begin
                                r_v[0] <= SAT32;
                                r_op <= next_op(r_op, r_enable_mask, r_three_d, r_vortex_mode);
                            end else begin
                                r_num <= {64'd0, r_t1};
                                r_den <= {24'd0, r_size, 8'd0};
                                r_state <= S_DIV;
                            end
                        end
                        OP_DS2: begin
                            r_ma <= r_size; r_mb <= r_size; r_state <= S_MUL;
                        end
                        OP_DNUM: begin
                            r_ma <= r_viscosity; r_mb <= r_time_step; r_state <= S_MUL;
                        end
                        OP_DDIV: begin
                            if (r_acc == '0) begin
                                r_v[1] <= SAT32;
                                r_op <= next_op(r_op, r_enable_mask, r_three_d, r_vortex_mode);
                            end else begin
                                r_num <= {64'd0, r_t1};
                                r_den <= r_acc;
                                r_state <= S_DIV;
                            end
                        end
                        OP_V0: begin
                            if (!r_vortex_mode) begin
                                r_ma <= mag_vort; r_mb <= r_time_step; r_state <= S_MUL;
                            end else if (r_viscosity == '0) begin
                                r_v[2] <= SAT32; r_op <= OP_DONE;
                            end else begin
                                r_op <= next_op(r_op, r_enable_mask, r_three_d, r_vortex_mode);
                            end
                        end
                        OP_V2D: begin
                            r_num <= {64'd0, magnitude32(r_str), 32'd0};
                            r_den <= {32'd0, r_viscosity};
                            r_state <= S_DIV;
                        end
                        // (vort*size) as 64 bits: lo and hi partial products
                        OP_VAL: begin
                            r_ma <= mag_vort; r_mb <= r_size; r_state <= S_MUL;
                        end
                        OP_VAH: begin
                            r_ma <= r_t1[31:0]; r_mb <= r_size; r_state <= S_MUL;
                        end
                        OP_VBL: begin
                            r_ma <= r_t1[63:32]; r_mb <= r_size; r_state <= S_MUL;
                        end
                        OP_VBH: begin
                            r_state <= S_NEXT;
                            r_op <= OP_V3D;
                        end
                        OP_V3D: begin
                            r_den <= {16'd0, r_viscosity, 16'd0};
                            r_state <= S_DIV;
                        end
                        default: begin
                            r_state <= S_FOLD;
                        end
                    endcase
                end
                S_MUL: begin
                    r_state <= S_NEXT;
                    r_op <= next_op(r_op, r_enable_mask, r_three_d, r_vortex_mode);
                    case (r_op)
                        OP_SQX, OP_SQY, OP_SQZ: r_acc <= r_acc + mprod;
                        OP_CNUM: r_t1 <= mprod;
                        OP_DS2:  r_acc <= mprod;
                        OP_DNUM: r_t1 <= mprod;
                        OP_V0: begin
                            r_v[2] <= mprod[63:32];
                            r_op <= OP_DONE;
                        end
                        OP_VAL:  r_t1 <= mprod;        // vort*size
                        OP_VAH:  r_num <= {64'd0, mprod}; // lo(vs)*size
                        // hi(vs)*size shifted by 32 into the 128-bit numerator
                        default: r_num <= r_num + {32'd0, mprod, 32'd0};
                    endcase
                end
                S_SQRT: begin
                    r_num <= {r_num[127:64], r_num[61:0], 2'b00};
                    if (sq_ge) begin
                        r_rem <= 64'(sq_rem_sh - sq_trial);
                        r_q <= {r_q[30:0], 1'b1};
                    end else begin
                        r_rem <= sq_rem_sh[63:0];
                        r_q <= {r_q[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd31) begin
                        r_t1 <= {32'd0, sq_ge ? {r_q[30:0], 1'b1} : {r_q[30:0], 1'b0}};
                        r_op <= OP_CNUM;
                        r_state <= S_NEXT;
                    end
                end
                S_DIV, S_AVG: begin
                    logic [31:0] qn;
                    logic        sn;
                    r_num <= {r_num[126:0], 1'b0};
                    sn = r_qsat | r_q[31];
                    qn = {r_q[30:0], div_ge};
                    if (div_ge) r_rem <= 64'(div_rem_sh - {1'b0, r_den});
                    else        r_rem <= div_rem_sh[63:0];
                    r_q <= qn; r_qsat <= sn;
                    r_cnt <= r_cnt + 7'd1;
                    if (r_state == S_AVG && r_cnt == 7'd0 && r_ci == 2'd0 &&
                        r_num == '0 && r_rem == '0 && r_q == '0) begin
                        // load first average
                        r_num <= {64'd0, r_sum[0]};
                        r_den <= {{(64-CNT_W){1'b0}}, r_count};
                        r_cnt <= 7'd0;
                        r_ci <= 2'd0;
                        r_state <= S_OUT;
                    end else if (r_cnt == 7'd127) begin
                        if (r_state == S_DIV) begin
                            case (r_op)
                                OP_CDIV: r_v[0] <= sn ? SAT32 : qn;
                                OP_DDIV: r_v[1] <= sn ? SAT32 : qn;
                                default: r_v[2] <= sn ? SAT32 : qn;
                            endcase
                            r_op <= (r_op == OP_CDIV || r_op == OP_DDIV) ?
                                    next_op(r_op, r_enable_mask, r_three_d, r_vortex_mode) :
                                    OP_DONE;
                            r_state <= S_NEXT;
                        end else begin
                            r_avg[r_ci] <= (r_count == '0 || !r_enable_mask[r_ci]) ? 32'd0 :
                                           (sn ? SAT32 : qn);
                            r_cnt <= '0; r_rem <= '0; r_q <= '0; r_qsat <= 1'b0;
                            if (r_ci == 2'd2) begin
                                r_state <= S_OUT;
                                r_ci <= 2'd3;
                            end else begin
                                r_ci <= r_ci + 2'd1;
                                r_num <= {64'd0, r_sum[r_ci + 2'd1]};
                            end
                        end
                    end
                end
                S_FOLD: begin
                    for (int i = 0; i < NUM_CRIT; i++) begin
                        r_sum[i] <= r_sum[i] + {32'd0, r_v[i]};
                        if (r_v[i] > r_smax[i]) r_smax[i] <= r_v[i];
                    end
                    r_count <= r_count + CNT_W'(1);
                    r_state <= r_last ? S_AVG : S_IDLE;
                    r_ci <= '0; r_cnt <= '0;
                    r_num <= '0; r_rem <= '0; r_q <= '0; r_qsat <= 1'b0;
                end
                S_OUT: begin
                    if (r_ci != 2'd3) begin
                        // averages start here
                        r_state <= S_AVG;
                        r_q <= '0; r_qsat <= 1'b0;
                        r_ci <= 2'd0;
                        r_den <= {{(64-CNT_W){1'b0}}, r_count};
                        r_cnt <= 7'd1;
                        // first shift step done here so the AVG entry test does not refire
                        r_num <= {63'd0, r_sum[0], 1'b0};
                        r_rem <= {63'd0, 1'b0};
                    end else if (!r_ovalid) begin
                        for (int i = 0; i < NUM_CRIT; i++) begin
                            r_out[2*i] <= r_avg[i];
                            r_out[2*i+1] <= r_enable_mask[i] ? r_smax[i] : 32'd0;
                            if (!r_enable_mask[i]) begin
                                r_lmax[i] <= '0;
                                r_out[6+i] <= '0;
                            end else if (is_init || r_smax[i] > r_lmax[i]) begin
                                r_lmax[i] <= r_smax[i];
                                r_out[6+i] <= r_smax[i];
                            end else begin
                                r_out[6+i] <= r_lmax[i];
                            end
                            r_sum[i] <= '0; r_smax[i] <= '0;
                        end
                        r_count <= '0;
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_courant_avg        = r_out[0];
    assign o_courant_max        = r_out[1];
    assign o_diffusion_avg      = r_out[2];
    assign o_diffusion_max      = r_out[3];
    assign o_vortex_avg         = r_out[4];
    assign o_vortex_max         = r_out[5];
    assign o_courant_life_max   = r_out[6];
    assign o_diffusion_life_max = r_out[7];
    assign o_vortex_life_max    = r_out[8];

endmodule
